[design/ca2d_pkg.sv]
// shared types and constants of the toroidal 2d cellular automaton
package ca2d_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);
  localparam int SIZE_W   = 7;
  localparam int CFG_W    = 32;
  localparam int RULE_W   = 32;
  localparam int CFG_AW   = 2;

  localparam logic [RULE_W-1:0] RULE_RESET = 32'd594594;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd10;

  // item modes
  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_ADVANCE = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_RULE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_DATA,
    ST_ADV_UP,
    ST_ADV_MID,
    ST_ADV_ROW
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_WRITE,
    DP_CLEAR,
    DP_READ_ISSUE,
    DP_READ_LOAD,
    DP_ADV_FETCH,
    DP_ADV_LOAD_UP,
    DP_ADV_LOAD_MID,
    DP_ADV_ROW
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic last_row;
  } dp_status_t;

endpackage

[design/ca2d_ctrl.sv]
// controller state machine: sequences write, read, clear and generation sweeps
module ca2d_ctrl
  import ca2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_mode,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (mode_t'(in_mode))
            MODE_WRITE: cmd.op = DP_WRITE;
            MODE_READ: begin
              cmd.op    = DP_READ_ISSUE;
              state_nxt = ST_RD_DATA;
            end
            MODE_ADVANCE: begin
              cmd.op    = DP_ADV_FETCH;
              state_nxt = ST_ADV_UP;
            end
            MODE_CLEAR: cmd.op = DP_CLEAR;
            default: cmd.op = DP_NOP;
          endcase
        end
      end
      ST_RD_DATA: begin
        cmd.op    = DP_READ_LOAD;
        state_nxt = ST_IDLE;
      end
      ST_ADV_UP: begin
        cmd.op    = DP_ADV_LOAD_UP;
        state_nxt = ST_ADV_MID;
      end
      ST_ADV_MID: begin
        cmd.op    = DP_ADV_LOAD_MID;
        state_nxt = ST_ADV_ROW;
      end
      ST_ADV_ROW: begin
        cmd.op = DP_ADV_ROW;
        if (status.last_row) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // sweep keeps going until the last row in use
  a_sweep_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADV_ROW && !status.last_row) |=> state_r == ST_ADV_ROW)
    else $error("generation sweep left early");

  // a read always passes through the data state
  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start && in_mode == MODE_READ) |=> state_r == ST_RD_DATA)
    else $error("read did not enter data state");

  // priming of a sweep runs the up state, then the mid state, then enters the row state
  a_prime: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ADV_UP |=> state_r == ST_ADV_MID ##1 state_r == ST_ADV_ROW)
    else $error("sweep priming out of order");

endmodule

[design/ca2d_dp.sv]
// datapath: config registers, row memory with valid bits, row window and rule logic
module ca2d_dp
  import ca2d_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  input  logic [ROW_AW-1:0]   in_row_number,
  input  logic [MAX_COLS-1:0] in_row_cells,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                out_valid,
  output logic [ROW_AW-1:0]   out_read_row_number,
  output logic [MAX_COLS-1:0] out_read_row_cells
);

  localparam logic [SIZE_W-1:0] MAX_COLS_S = SIZE_W'(MAX_COLS);
  localparam logic [SIZE_W-1:0] MAX_ROWS_S = SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] ONE_S      = SIZE_W'(1);

  logic [RULE_W-1:0]   rule_r;
  logic [SIZE_W-1:0]   width_r;
  logic [SIZE_W-1:0]   height_r;
  logic [SIZE_W-1:0]   w_eff;
  logic [SIZE_W-1:0]   h_eff;
  logic [COL_AW-1:0]   wm1;
  logic [ROW_AW-1:0]   hm1;
  logic [MAX_COLS-1:0] col_mask;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] valid_r;
  logic [MAX_COLS-1:0] rdata_r;
  logic                rvalid_r;
  logic [ROW_AW-1:0]   rd_addr;
  logic [MAX_COLS-1:0] fetched;

  logic [MAX_COLS-1:0] up_r;
  logic [MAX_COLS-1:0] mid_r;
  logic [MAX_COLS-1:0] first_r;
  logic [MAX_COLS-1:0] down;
  logic [MAX_COLS-1:0] left_v;
  logic [MAX_COLS-1:0] right_v;
  logic [MAX_COLS-1:0] next_row;
  logic [ROW_AW-1:0]   y_r;
  logic [SIZE_W-1:0]   y_plus2;

  logic [ROW_AW-1:0]   rd_row_r;
  logic                rd_in_r;
  logic                out_valid_r;
  logic [ROW_AW-1:0]   out_row_r;
  logic [MAX_COLS-1:0] out_cells_r;
  logic                size_write;

  // effective sizes, clamped to 1..max
  always_comb begin
    if (width_r == '0) w_eff = ONE_S;
    else if (width_r > MAX_COLS_S) w_eff = MAX_COLS_S;
    else w_eff = width_r;
    if (height_r == '0) h_eff = ONE_S;
    else if (height_r > MAX_ROWS_S) h_eff = MAX_ROWS_S;
    else h_eff = height_r;
  end

  assign wm1 = COL_AW'(w_eff - ONE_S);
  assign hm1 = ROW_AW'(h_eff - ONE_S);

  // columns in use
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (SIZE_W'(c) < w_eff);
    end
  end

  // config registers
  assign size_write = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r   <= RULE_RESET;
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RULE:   rule_r   <= cfg_data[RULE_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // read address select
  assign y_plus2 = {1'b0, y_r} + SIZE_W'(2);

  always_comb begin
    case (cmd.op)
      DP_READ_ISSUE:   rd_addr = in_row_number;
      DP_ADV_FETCH:    rd_addr = hm1;
      DP_ADV_LOAD_UP:  rd_addr = '0;
      DP_ADV_LOAD_MID: rd_addr = (h_eff == ONE_S) ? '0 : ROW_AW'(1);
      DP_ADV_ROW:      rd_addr = (y_plus2 < h_eff) ? ROW_AW'(y_plus2) : '0;
      default:         rd_addr = '0;
    endcase
  end

  // row memory
  always_ff @(posedge clk) begin
    if (cmd.op == DP_WRITE && {1'b0, in_row_number} < h_eff) begin
      mem[in_row_number] <= in_row_cells & col_mask;
    end else if (cmd.op == DP_ADV_ROW) begin
      mem[y_r] <= next_row;
    end
    rdata_r  <= mem[rd_addr];
    rvalid_r <= valid_r[rd_addr];
  end

  // valid bits: a row never written since the last clear, reset or size write reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.op == DP_CLEAR || size_write) begin
      valid_r <= '0;
    end else if (cmd.op == DP_WRITE && {1'b0, in_row_number} < h_eff) begin
      valid_r[in_row_number] <= 1'b1;
    end else if (cmd.op == DP_ADV_ROW) begin
      valid_r[y_r] <= 1'b1;
    end
  end

  assign fetched = rvalid_r ? rdata_r : '0;

  // down row: original row zero at the bottom wrap
  assign status.last_row = (y_r == hm1);
  assign down = status.last_row ? first_r : fetched;

  // horizontal neighbours with wrap inside the width in use
  always_comb begin
    left_v      = mid_r << 1;
    left_v[0]   = mid_r[wm1];
    right_v     = mid_r >> 1;
    right_v[wm1] = mid_r[0];
  end

  // rule lookup per column
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      next_row[c] = rule_r[{up_r[c], left_v[c], mid_r[c], right_v[c], down[c]}] & col_mask[c];
    end
  end

  // row window and sweep counter
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_ADV_FETCH: y_r <= '0;
      DP_ADV_LOAD_UP: up_r <= fetched;
      DP_ADV_LOAD_MID: begin
        mid_r   <= fetched;
        first_r <= fetched;
      end
      DP_ADV_ROW: begin
        up_r  <= mid_r;
        mid_r <= down;
        y_r   <= y_r + ROW_AW'(1);
      end
      default: ;
    endcase
  end

  // read result path
  always_ff @(posedge clk) begin
    if (cmd.op == DP_READ_ISSUE) begin
      rd_row_r <= in_row_number;
      rd_in_r  <= ({1'b0, in_row_number} < h_eff);
    end
    if (cmd.op == DP_READ_LOAD) begin
      out_row_r   <= rd_row_r;
      out_cells_r <= rd_in_r ? (fetched & col_mask) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == DP_READ_LOAD);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_row_number = out_row_r;
  assign out_read_row_cells  = out_cells_r;

  // a clear leaves every row reading zero
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_CLEAR || size_write) |=> valid_r == '0)
    else $error("clear left valid rows");

  // sweep counter stays inside the height in use
  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_ADV_ROW |-> {1'b0, y_r} < h_eff)
    else $error("sweep row outside height");

  // columns beyond the width never show up in a read word
  a_cols: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_read_row_cells & ~$past(col_mask)) == '0)
    else $error("read word has columns beyond width");

endmodule

[design/toroidal_2d_cellular_automaton.sv]
// top level of the toroidal 2d cellular automaton: controller plus datapath
// Usage:
//   Pulse start with in_mode, in_row_number and in_row_cells while busy is low;
//   the word is taken at that edge. Modes: write row, read row, advance one
//   generation, clear grid.
//   Write and clear leave busy low. A read holds busy high for one cycle
//   and its word appears on out_read_row_number and out_read_row_cells
//   with out_valid for exactly one cycle, after the row memory read
//   register and then the output registers. Busy falls as out_valid rises,
//   so a new start can be taken at the edge that takes the word.
//   An advance fetches the last row in use, primes the up and middle rows,
//   then sweeps one row per cycle through the single read port
//   of the row memory, rows being updated in place.
//   The receiver cannot stall; out_valid is a one-cycle strobe.
//   Config writes (cfg_we, cfg_index, cfg_data) take effect at once; a write
//   to width or height clears the grid. Write only while idle.
//   Reset (rst_n low, synchronous) clears the grid through per-row valid bits
//   and restores rule, width and height to their reset values.
module toroidal_2d_cellular_automaton
  import ca2d_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_mode,
  input  logic [ROW_AW-1:0]   in_row_number,
  input  logic [MAX_COLS-1:0] in_row_cells,
  output logic                out_valid,
  output logic [ROW_AW-1:0]   out_read_row_number,
  output logic [MAX_COLS-1:0] out_read_row_cells,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller
  ca2d_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  // datapath
  ca2d_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_row_number       (in_row_number),
    .in_row_cells        (in_row_cells),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_read_row_number (out_read_row_number),
    .out_read_row_cells  (out_read_row_cells)
  );

  // every read start taken while idle brings its word on out_valid
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_READ) |-> ##2 out_valid)
    else $error("read word missing");

  // other modes give no word
  a_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode != MODE_READ) |-> ##2 !out_valid)
    else $error("word without a read");

  // strobes never come in adjacent cycles
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("adjacent read strobes");

endmodule
